// ===== sv/idt_pkg.sv =====
// Shared types, constants and helpers of the integer to decimal text formatter.
// Used by the channel interfaces and by the top level; depends on nothing else.
package idt_pkg;

	localparam int VALUE_W      = 32;
	localparam int CHAR_W       = 8;
	localparam int DIGIT_W      = 4;
	localparam int NUM_DIGITS   = 10;
	localparam int DIGIT_STAGES = NUM_DIGITS - 1;
	localparam int NUM_SLOTS    = 14;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 8;
	localparam int WIDTH_W      = 4;
	localparam int POW_W        = 34;

	localparam logic [CHAR_W-1:0]  CHR_ZERO   = 8'h30;
	localparam logic [CHAR_W-1:0]  CHR_MINUS  = 8'h2d;
	localparam logic [CHAR_W-1:0]  CHR_SPACE  = 8'h20;
	localparam logic [WIDTH_W-1:0] WIDTH_FULL = 4'd10;
	localparam logic [WIDTH_W-1:0] WIDTH_MAX  = 4'd9;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SIGNED_MODE = 2'd0,
		REG_MIN_WIDTH   = 2'd1,
		REG_PAD_CHAR    = 2'd2,
		REG_GROUP_SEP   = 2'd3
	} reg_idx_t;

	// Conversion stage payload: sign, running remainder, digits found so far
	typedef struct packed {
		logic                              neg;
		logic [VALUE_W-1:0]                rem;
		logic [NUM_DIGITS-1:0][DIGIT_W-1:0] dig;
	} cnv_t;

	// Power of ten for a digit position
	function automatic logic [POW_W-1:0] pow10(input int e);
		logic [POW_W-1:0] p;
		case (e)
			0:       p = 34'd1;
			1:       p = 34'd10;
			2:       p = 34'd100;
			3:       p = 34'd1000;
			4:       p = 34'd10000;
			5:       p = 34'd100000;
			6:       p = 34'd1000000;
			7:       p = 34'd10000000;
			8:       p = 34'd100000000;
			9:       p = 34'd1000000000;
			default: p = 34'd1;
		endcase
		return p;
	endfunction

	// Output slot of the digit at position e (below one billion); the
	// separator ahead of positions 8, 5 and 2 sits one slot earlier
	function automatic int digit_slot(input int e);
		int s;
		s = 13 - e - ((e >= 3) ? 1 : 0) - ((e >= 6) ? 1 : 0);
		return s;
	endfunction

endpackage

// ===== sv/idt_in_if.sv =====
// Input channel of the formatter: one 32-bit value per beat.
// Depends on idt_pkg for the field width.
interface idt_in_if;
	logic                        valid;
	logic                        ready;
	logic [idt_pkg::VALUE_W-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

// ===== sv/idt_out_if.sv =====
// Output channel of the formatter: one ASCII character per beat with a last flag.
// Depends on idt_pkg for the field width.
interface idt_out_if;
	logic                       valid;
	logic                       ready;
	logic [idt_pkg::CHAR_W-1:0] character;
	logic                       last_char;

	modport source (output valid, output character, output last_char, input ready);
	modport sink (input valid, input character, input last_char, output ready);
endinterface

// ===== sv/int_to_decimal_text_formatter.sv =====
// Integer to decimal text formatter. Each 32-bit value accepted on din comes
// out on dout as 1 to 14 ASCII characters, leftmost first, last_char set on
// the final one. A number's characters leave one per cycle while dout is
// ready; the character serialiser at the end sets that rate. Values enter at
// one per cycle while the pipeline has room, and pass in order through the
// registered sign stage, nine digit stages, layout stage and serialiser
// before their first character is offered. Besides the pipeline, the only
// state is four configuration registers, written through cfg_we, cfg_idx and
// cfg_wdata; the user must write them only while no number is in flight, as
// the block itself does not enforce it.
// Depends on idt_pkg, idt_in_if and idt_out_if.
module int_to_decimal_text_formatter (
	input  logic                           clk,
	input  logic                           arst_n,
	idt_in_if.sink                         din,
	idt_out_if.source                      dout,
	input  logic                           cfg_we,
	input  logic [idt_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [idt_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	localparam int NS = idt_pkg::NUM_SLOTS;
	localparam int ND = idt_pkg::DIGIT_STAGES;

	// Configuration registers
	logic                          signed_mode_q;
	logic [idt_pkg::WIDTH_W-1:0]   min_width_q;
	logic [idt_pkg::CHAR_W-1:0]    pad_char_q;
	logic [idt_pkg::CHAR_W-1:0]    group_sep_q;

	// Pipeline
	logic                          sgn_v_s1;
	idt_pkg::cnv_t                 sgn_s1;
	logic                          cnv_v_s [0:ND-1];
	idt_pkg::cnv_t                 cnv_s   [0:ND-1];
	idt_pkg::cnv_t                 cnv_in  [0:ND];
	logic                          adv     [0:ND];
	logic                          fmt_v_s11;
	logic [NS-1:0]                 fmt_en_s11;
	logic [NS-1:0][idt_pkg::CHAR_W-1:0] fmt_chr_s11;
	logic                          fmt_adv;

	// Serialiser
	logic [NS-1:0]                 ser_mask_q;
	logic [NS-1:0][idt_pkg::CHAR_W-1:0] ser_chr_q;
	logic [NS-1:0]                 ser_first;
	logic [NS-1:0]                 ser_rest;
	logic                          ser_last;
	logic                          ser_load;
	logic                          out_beat;

	// Layout stage signals
	logic [idt_pkg::NUM_DIGITS*idt_pkg::DIGIT_W-1:0] dflat;
	logic [idt_pkg::NUM_DIGITS-1:0] nz_at;
	logic                          big;
	logic                          wfull;
	logic [idt_pkg::WIDTH_W-1:0]   wopen;
	logic [idt_pkg::CHAR_W-1:0]    fill;
	logic [NS-1:0]                 slot_en;
	logic [NS-1:0][idt_pkg::CHAR_W-1:0] slot_chr;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			signed_mode_q <= 1'b1;
			min_width_q   <= '0;
			pad_char_q    <= '0;
			group_sep_q   <= '0;
		end else if (cfg_we) begin
			case (idt_pkg::reg_idx_t'(cfg_idx))
				idt_pkg::REG_SIGNED_MODE: signed_mode_q <= cfg_wdata[0];
				idt_pkg::REG_MIN_WIDTH:   min_width_q   <= cfg_wdata[idt_pkg::WIDTH_W-1:0];
				idt_pkg::REG_PAD_CHAR:    pad_char_q    <= cfg_wdata;
				idt_pkg::REG_GROUP_SEP:   group_sep_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Advance chain: a stage moves when empty or when the next one moves
	assign adv[ND]   = fmt_adv;
	assign din.ready = !sgn_v_s1 || adv[0];

	// Sign stage: take the magnitude
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sgn_v_s1 <= 1'b0;
		end else if (din.ready) begin
			sgn_v_s1 <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (din.ready && din.valid) begin
			sgn_s1.neg <= signed_mode_q && din.value[idt_pkg::VALUE_W-1];
			sgn_s1.rem <= (signed_mode_q && din.value[idt_pkg::VALUE_W-1]) ?
				(~din.value + 32'd1) : din.value;
			sgn_s1.dig <= '0;
		end
	end

	assign cnv_in[0] = sgn_s1;

	// Digit stages: one decimal digit per stage, billions first
	for (genvar i = 0; i < ND; i++) begin : g_digit
		localparam int E = idt_pkg::NUM_DIGITS - 1 - i;
		localparam logic [idt_pkg::POW_W-1:0] POW = idt_pkg::pow10(E);
		logic [idt_pkg::POW_W-1:0]   sub;
		logic [idt_pkg::DIGIT_W-1:0] dgt;
		idt_pkg::cnv_t               nxt;
		logic                        v_in;

		assign v_in   = (i == 0) ? sgn_v_s1 : cnv_v_s[(i == 0) ? 0 : i-1];
		assign adv[i] = !cnv_v_s[i] || adv[i+1];

		// Compare against each multiple of the power and subtract the largest that fits
		always_comb begin
			sub = '0;
			dgt = '0;
			for (int k = 1; k < 10; k++) begin
				if ({2'b00, cnv_in[i].rem} >= idt_pkg::POW_W'(k) * POW) begin
					sub = idt_pkg::POW_W'(k) * POW;
					dgt = idt_pkg::DIGIT_W'(k);
				end
			end
			nxt        = cnv_in[i];
			nxt.rem    = cnv_in[i].rem - sub[idt_pkg::VALUE_W-1:0];
			nxt.dig[E] = dgt;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cnv_v_s[i] <= 1'b0;
			end else if (adv[i]) begin
				cnv_v_s[i] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv[i] && v_in) begin
				cnv_s[i] <= nxt;
			end
		end

		assign cnv_in[i+1] = cnv_s[i];
	end

	// Layout: decide which slots are shown and what each carries
	always_comb begin
		dflat = {cnv_in[ND].dig[idt_pkg::NUM_DIGITS-1:1], cnv_in[ND].rem[idt_pkg::DIGIT_W-1:0]};
		for (int e = 0; e < idt_pkg::NUM_DIGITS; e++) begin
			nz_at[e] = |(dflat >> (idt_pkg::DIGIT_W * e));
		end
		big   = nz_at[idt_pkg::NUM_DIGITS-1];
		wfull = (min_width_q == idt_pkg::WIDTH_FULL);
		if (big || wfull) begin
			wopen = idt_pkg::WIDTH_MAX;
		end else if (min_width_q <= idt_pkg::WIDTH_MAX) begin
			wopen = min_width_q;
		end else begin
			wopen = '0;
		end
		fill = (pad_char_q != '0) ? pad_char_q : idt_pkg::CHR_SPACE;

		slot_en  = '0;
		slot_chr = '0;
		slot_en[0]  = cnv_in[ND].neg;
		slot_chr[0] = idt_pkg::CHR_MINUS;
		slot_en[1]  = big || wfull;
		slot_chr[1] = big ? (idt_pkg::CHR_ZERO + {4'b0000, dflat[39:36]}) : idt_pkg::CHR_SPACE;
		for (int e = 0; e < idt_pkg::NUM_DIGITS - 1; e++) begin
			// separator once display has begun ahead of this group
			if (e == 8 || e == 5 || e == 2) begin
				slot_en[idt_pkg::digit_slot(e) - 1] = (group_sep_q != '0) &&
					((idt_pkg::WIDTH_W'(e) < wopen) || nz_at[e+1]);
				slot_chr[idt_pkg::digit_slot(e) - 1] = group_sep_q;
			end
			// units digit always shows; others inside the window or after a nonzero digit
			slot_en[idt_pkg::digit_slot(e)] = (idt_pkg::WIDTH_W'(e) < wopen) || nz_at[e] ||
				(e == 0);
			slot_chr[idt_pkg::digit_slot(e)] = (!nz_at[e] && e != 0) ? fill :
				(idt_pkg::CHR_ZERO + {4'b0000, dflat[idt_pkg::DIGIT_W*e +: idt_pkg::DIGIT_W]});
		end
	end

	assign fmt_adv = !fmt_v_s11 || ser_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_v_s11 <= 1'b0;
		end else if (fmt_adv) begin
			fmt_v_s11 <= cnv_v_s[ND-1];
		end
	end

	always_ff @(posedge clk) begin
		if (fmt_adv && cnv_v_s[ND-1]) begin
			fmt_en_s11  <= slot_en;
			fmt_chr_s11 <= slot_chr;
		end
	end

	// Serialiser: emit the lowest pending slot each beat
	assign ser_first = ser_mask_q & (~ser_mask_q + 14'd1);
	assign ser_rest  = ser_mask_q & (ser_mask_q - 14'd1);
	assign ser_last  = (ser_rest == '0);
	assign out_beat  = dout.valid && dout.ready;
	assign ser_load  = fmt_v_s11 && ((ser_mask_q == '0) || (out_beat && ser_last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ser_mask_q <= '0;
		end else if (ser_load) begin
			ser_mask_q <= fmt_en_s11;
		end else if (out_beat) begin
			ser_mask_q <= ser_rest;
		end
	end

	always_ff @(posedge clk) begin
		if (ser_load) begin
			ser_chr_q <= fmt_chr_s11;
		end
	end

	// Pick the character of the lowest pending slot
	always_comb begin
		dout.character = '0;
		for (int s = 0; s < NS; s++) begin
			if (ser_first[s]) begin
				dout.character = dout.character | ser_chr_q[s];
			end
		end
	end

	assign dout.valid     = (ser_mask_q != '0);
	assign dout.last_char = ser_last;

	// The units digit closes every number, so it is pending while a number is out
	a_units_pending: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid |-> ser_mask_q[NS-1])
		else $error("serialiser holds a number without its units digit");

	// A laid-out number always carries its units digit
	a_fmt_units: assert property (@(posedge clk) disable iff (!arst_n)
		fmt_v_s11 |-> fmt_en_s11[NS-1])
		else $error("layout stage produced a number without its units digit");

	// The input stalls only when every stage is full
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!din.ready |-> (sgn_v_s1 && cnv_v_s[0] && cnv_v_s[ND-1] && fmt_v_s11))
		else $error("input stalled with room in the pipeline");

	// With nothing waiting, the final beat empties the output
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_beat && dout.last_char && !fmt_v_s11) |=> !dout.valid)
		else $error("output stayed valid after the final character");

endmodule

// ===== dv/testbench.sv =====
// Self-checking bench for the integer to decimal text formatter: table of
// directed numbers, then random numbers under changing formats and idling.
// Depends on idt_pkg, idt_in_if, idt_out_if and int_to_decimal_text_formatter.
module testbench;

	localparam int CYCLE_LIMIT = 200000;

	// One expected output beat
	typedef struct packed {
		logic [idt_pkg::CHAR_W-1:0] character;
		logic                       last_char;
	} text_beat_t;

	// Directed row: format, number and, where obvious, its text
	typedef struct {
		bit                          sgn;
		logic [idt_pkg::WIDTH_W-1:0] width;
		logic [idt_pkg::CHAR_W-1:0]  pad;
		logic [idt_pkg::CHAR_W-1:0]  sep;
		logic [idt_pkg::VALUE_W-1:0] value;
		string                       text;
	} number_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [idt_pkg::CFG_IDX_W-1:0]  cfg_idx;
	logic [idt_pkg::CFG_DATA_W-1:0] cfg_wdata;

	idt_in_if  in_ch();
	idt_out_if out_ch();

	int_to_decimal_text_formatter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.din       (in_ch),
		.dout      (out_ch),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	// Format copy, starting at the register reset values
	bit                          signed_cfg = 1'b1;
	logic [idt_pkg::WIDTH_W-1:0] width_cfg  = '0;
	logic [idt_pkg::CHAR_W-1:0]  pad_cfg    = '0;
	logic [idt_pkg::CHAR_W-1:0]  sep_cfg    = '0;

	text_beat_t text_q[$];
	int mismatch_count = 0;
	int cycles_run = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	number_row_t number_rows[25] = '{
		'{1'b1, 4'd0,  8'h00, 8'h00, 32'd0,          "0"},
		'{1'b1, 4'd0,  8'h00, 8'h00, 32'd1,          "1"},
		'{1'b1, 4'd0,  8'h00, 8'h00, 32'h7FFFFFFF,   "2147483647"},
		'{1'b1, 4'd0,  8'h00, 8'h00, 32'h80000000,   "-2147483648"},
		'{1'b1, 4'd0,  8'h00, 8'h00, 32'hFFFFFFFF,   "-1"},
		'{1'b0, 4'd0,  8'h00, 8'h00, 32'hFFFFFFFF,   "4294967295"},
		'{1'b0, 4'd0,  8'h00, 8'h00, 32'd1000000000, "1000000000"},
		'{1'b0, 4'd0,  8'h00, 8'h00, 32'd999999999,  "999999999"},
		'{1'b0, 4'd10, 8'h30, 8'h00, 32'd5,          " 000000005"},
		'{1'b0, 4'd10, 8'h00, 8'h00, 32'd0,          "         0"},
		'{1'b0, 4'd3,  8'h2A, 8'h00, 32'd7,          "**7"},
		'{1'b0, 4'd3,  8'h2A, 8'h00, 32'd0,          "**0"},
		'{1'b0, 4'd15, 8'h2A, 8'h00, 32'd42,         "42"},
		'{1'b0, 4'd11, 8'h2A, 8'h00, 32'd0,          "0"},
		'{1'b0, 4'd1,  8'h23, 8'h00, 32'd0,          "0"},
		'{1'b0, 4'd9,  8'h30, 8'h00, 32'd12345,      "000012345"},
		'{1'b0, 4'd0,  8'h00, 8'h2C, 32'd1234567,    "1,234,567"},
		'{1'b1, 4'd0,  8'h00, 8'h2C, 32'h80000000,   "-2,147,483,648"},
		'{1'b1, 4'd6,  8'h00, 8'h2C, 32'd12,         ""},
		'{1'b1, 4'd9,  8'h30, 8'h2C, 32'd0,          ""},
		'{1'b1, 4'd10, 8'h30, 8'h2C, 32'd123,        ""},
		'{1'b1, 4'd2,  8'hFF, 8'hFF, 32'hFFFFFF85,   ""},
		'{1'b0, 4'd15, 8'hFF, 8'hFF, 32'hFFFFFFFF,   ""},
		'{1'b0, 4'd5,  8'h30, 8'h00, 32'h55555555,   ""},
		'{1'b1, 4'd4,  8'h30, 8'h00, 32'hAAAAAAAA,   ""}
	};

	// Work out the decimal text of one number under the current format
	function automatic void predict_text(input logic [idt_pkg::VALUE_W-1:0] v);
		logic [idt_pkg::CHAR_W-1:0]  chars[$];
		logic [idt_pkg::VALUE_W-1:0] mag;
		logic [idt_pkg::VALUE_W-1:0] place;
		logic [idt_pkg::VALUE_W-1:0] d;
		logic [idt_pkg::CHAR_W-1:0]  fill;
		bit shown;
		bit blank;
		int skip;
		int body;
		mag   = v;
		fill  = (pad_cfg != '0) ? pad_cfg : idt_pkg::CHR_SPACE;
		shown = 1'b0;
		blank = 1'b1;
		skip  = 9;
		if (signed_cfg && mag[idt_pkg::VALUE_W-1]) begin
			chars.push_back(idt_pkg::CHR_MINUS);
			mag = '0 - mag;
		end
		body = chars.size();
		// Billions digit, or the full-width leading space, or the padding window
		if (mag >= 32'd1000000000) begin
			chars.push_back(idt_pkg::CHR_ZERO + idt_pkg::CHAR_W'(mag / 32'd1000000000));
			mag   = mag % 32'd1000000000;
			shown = 1'b1;
			blank = 1'b0;
		end else if (width_cfg == idt_pkg::WIDTH_FULL) begin
			chars.push_back(idt_pkg::CHR_SPACE);
			shown = 1'b1;
		end else begin
			skip  = (width_cfg <= idt_pkg::WIDTH_MAX) ? 9 - int'(width_cfg) : 9;
			shown = (skip == 0);
		end
		for (int e = 8; e >= 0; e--) begin
			place = 1;
			repeat (e) place = place * 10;
			d   = mag / place;
			mag = mag % place;
			if ((e == 8 || e == 5 || e == 2) && sep_cfg != '0 && shown)
				chars.push_back(sep_cfg);
			if (d != 0) begin
				shown = 1'b1;
				blank = 1'b0;
			end
			if (shown) begin
				chars.push_back((blank && e != 0) ? fill :
					idt_pkg::CHR_ZERO + idt_pkg::CHAR_W'(d));
			end else begin
				skip--;
				shown = (skip == 0);
			end
		end
		// Zero with no padding still shows its units digit
		if (chars.size() == body)
			chars.push_back(idt_pkg::CHR_ZERO);
		foreach (chars[k])
			text_q.push_back(text_beat_t'{chars[k], k == chars.size() - 1});
	endfunction

	// Offer one number, optionally after an idle gap, and book its text
	task automatic send_value(input logic [idt_pkg::VALUE_W-1:0] v, input string typed);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			do begin
				in_ch.valid <= 1'b0;
				@(posedge clk);
			end while ($urandom_range(0, 99) < send_idle_pct);
		end
		in_ch.valid <= 1'b1;
		in_ch.value <= v;
		do @(posedge clk); while (!in_ch.ready);
		if (typed.len() == 0) begin
			predict_text(v);
		end else begin
			for (int k = 0; k < typed.len(); k++)
				text_q.push_back(text_beat_t'{typed[k], k == typed.len() - 1});
		end
	endtask

	// Hold off the sender until every booked character has come out
	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		while (text_q.size() != 0) @(posedge clk);
	endtask

	// Drain, then write all four format registers
	task automatic set_format(input bit s, input logic [idt_pkg::WIDTH_W-1:0] w,
			input logic [idt_pkg::CHAR_W-1:0] p, input logic [idt_pkg::CHAR_W-1:0] g);
		wait_drained();
		repeat (2) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= idt_pkg::REG_SIGNED_MODE;
		cfg_wdata <= idt_pkg::CFG_DATA_W'(s);
		@(posedge clk);
		cfg_idx   <= idt_pkg::REG_MIN_WIDTH;
		cfg_wdata <= idt_pkg::CFG_DATA_W'(w);
		@(posedge clk);
		cfg_idx   <= idt_pkg::REG_PAD_CHAR;
		cfg_wdata <= p;
		@(posedge clk);
		cfg_idx   <= idt_pkg::REG_GROUP_SEP;
		cfg_wdata <= g;
		@(posedge clk);
		cfg_we     <= 1'b0;
		signed_cfg = s;
		width_cfg  = w;
		pad_cfg    = p;
		sep_cfg    = g;
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Cycle limit
	initial begin
		while (cycles_run < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles_run++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	// Check each output beat against the oldest booked character; stall at random
	always @(posedge clk) begin
		text_beat_t want;
		if (out_ch.valid && out_ch.ready) begin
			if (text_q.size() == 0) begin
				$error("character: expected none, got %h", out_ch.character);
				mismatch_count++;
			end else begin
				want = text_q.pop_front();
				if (out_ch.character !== want.character) begin
					$error("character: expected %h, got %h", want.character,
						out_ch.character);
					mismatch_count++;
				end
				if (out_ch.last_char !== want.last_char) begin
					$error("last_char: expected %b, got %b", want.last_char,
						out_ch.last_char);
					mismatch_count++;
				end
			end
		end
		out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	initial begin
		logic [idt_pkg::VALUE_W-1:0] v;
		logic [idt_pkg::VALUE_W-1:0] lim;
		arst_n       <= 1'b0;
		cfg_we       <= 1'b0;
		cfg_idx      <= idt_pkg::REG_SIGNED_MODE;
		cfg_wdata    <= '0;
		in_ch.valid  <= 1'b0;
		in_ch.value  <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table, first rows under the reset format
		foreach (number_rows[r]) begin
			if (number_rows[r].sgn != signed_cfg || number_rows[r].width != width_cfg ||
					number_rows[r].pad != pad_cfg || number_rows[r].sep != sep_cfg)
				set_format(number_rows[r].sgn, number_rows[r].width,
					number_rows[r].pad, number_rows[r].sep);
			send_value(number_rows[r].value, number_rows[r].text);
		end

		// Random numbers: three idling regimes, four formats in each
		for (int regime = 0; regime < 3; regime++) begin
			send_idle_pct = (regime == 0) ? 38 : (regime == 1) ? 74 : 0;
			recv_idle_pct = (regime == 0) ? 74 : (regime == 1) ? 38 : 0;
			for (int phase = 0; phase < 4; phase++) begin
				set_format(bit'($urandom_range(0, 1)),
					($urandom_range(0, 3) == 0) ?
						idt_pkg::WIDTH_W'($urandom_range(11, 15)) :
						idt_pkg::WIDTH_W'($urandom_range(0, 10)),
					($urandom_range(0, 2) == 0) ? 8'h00 :
						idt_pkg::CHAR_W'($urandom_range(0, 255)),
					($urandom_range(0, 1) == 0) ? 8'h00 :
						idt_pkg::CHAR_W'($urandom_range(1, 255)));
				for (int n = 0; n < 15; n++) begin
					case ($urandom_range(0, 5))
						0: v = $urandom;
						1: v = $urandom_range(0, 999);
						2: begin
							lim = 1;
							repeat ($urandom_range(1, 9)) lim = lim * 10;
							v = $urandom % lim;
						end
						3: v = 32'd0 - $urandom_range(1, 100000);
						4: begin
							case ($urandom_range(0, 5))
								0:       v = 32'd999999999;
								1:       v = 32'd1000000000;
								2:       v = 32'h7FFFFFFF;
								3:       v = 32'h80000000;
								4:       v = 32'hFFFFFFFF;
								default: v = 32'd0;
							endcase
						end
						default: v = $urandom_range(32'd1000000000, 32'hFFFFFFFF);
					endcase
					// Now and then hold off until the output has caught up
					if ($urandom_range(0, 29) == 0)
						wait_drained();
					send_value(v, "");
				end
			end
		end

		wait_drained();
		repeat (16) @(posedge clk);
		if (mismatch_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
